FILE: sv/sed_pkg.sv
// Shared types, constants and helper functions for the string escape decoder.
`timescale 1ns / 1ps

package sed_pkg;

   localparam int RECS   = 4;
   localparam int IDX_W  = $clog2(RECS);
   localparam int CNT_W  = $clog2(RECS + 1);
   localparam int QDEPTH = 4;
   localparam int PTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [31:0] CP_MAX  = 32'h0010_ffff;
   localparam logic [31:0] SURR_LO = 32'h0000_d800;
   localparam logic [31:0] SURR_HI = 32'h0000_dfff;

   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_BSLASH = 8'h5c;
   localparam logic [7:0] CH_0      = 8'h30;
   localparam logic [7:0] CH_7      = 8'h37;
   localparam logic [7:0] CH_9      = 8'h39;
   localparam logic [7:0] CH_UP_A   = 8'h41;
   localparam logic [7:0] CH_UP_F   = 8'h46;
   localparam logic [7:0] CH_UP_N   = 8'h4e;
   localparam logic [7:0] CH_UP_U   = 8'h55;
   localparam logic [7:0] CH_LOW_A  = 8'h61;
   localparam logic [7:0] CH_LOW_B  = 8'h62;
   localparam logic [7:0] CH_LOW_F  = 8'h66;
   localparam logic [7:0] CH_LOW_N  = 8'h6e;
   localparam logic [7:0] CH_LOW_R  = 8'h72;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_LOW_U  = 8'h75;
   localparam logic [7:0] CH_LOW_V  = 8'h76;
   localparam logic [7:0] CH_LOW_X  = 8'h78;

   typedef enum logic [2:0] {
      MODE_NORMAL = 3'd0,
      MODE_ESC    = 3'd1,
      MODE_OCTAL  = 3'd2,
      MODE_HEX    = 3'd3,
      MODE_UNI    = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_ERROR = 2'd1,
      KIND_MARK  = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ERR_EOF          = 3'd0,
      ERR_TRUNC_X      = 3'd1,
      ERR_TRUNC_U      = 3'd2,
      ERR_TRUNC_LONG_U = 3'd3,
      ERR_BAD_CP       = 3'd4,
      ERR_NAMED        = 3'd5
   } err_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      err_type     code;
   } rec_type;

   typedef struct packed {
      rec_type [RECS-1:0] recs;
      logic [CNT_W-1:0]   count;
      logic               lit_end;
   } entry_type;

   typedef struct packed {
      logic [2:0]       len;
      logic [3:0][7:0]  bytes;
   } utf8_type;

   function automatic utf8_type cp_to_utf8(logic [20:0] cp);
      utf8_type u;
      u = '0;
      if (cp < 21'h80) begin
         u.len      = 3'd1;
         u.bytes[0] = cp[7:0];
      end else if (cp < 21'h800) begin
         u.len      = 3'd2;
         u.bytes[0] = {3'b110, cp[10:6]};
         u.bytes[1] = {2'b10, cp[5:0]};
      end else if (cp < 21'h10000) begin
         u.len      = 3'd3;
         u.bytes[0] = {4'b1110, cp[15:12]};
         u.bytes[1] = {2'b10, cp[11:6]};
         u.bytes[2] = {2'b10, cp[5:0]};
      end else begin
         u.len      = 3'd4;
         u.bytes[0] = {5'b11110, cp[20:18]};
         u.bytes[1] = {2'b10, cp[17:12]};
         u.bytes[2] = {2'b10, cp[11:6]};
         u.bytes[3] = {2'b10, cp[5:0]};
      end
      return u;
   endfunction

   function automatic entry_type put_rec(entry_type e, kind_type k, logic [7:0] d,
                                         err_type code);
      rec_type r;
      r.kind = k;
      r.data = d;
      r.code = code;
      if (e.count < CNT_W'(RECS)) begin
         e.recs[e.count[IDX_W-1:0]] = r;
         e.count = e.count + 1'b1;
      end
      return e;
   endfunction

   function automatic entry_type put_utf8(entry_type e, utf8_type u);
      for (int i = 0; i < 4; i++) begin
         if (3'(i) < u.len) begin
            e = put_rec(e, KIND_BYTE, u.bytes[i], ERR_EOF);
         end
      end
      return e;
   endfunction

endpackage

FILE: sv/sed_front.sv
// Front end: escape state machine that turns each accepted source byte into at most one queue word.
`timescale 1ns / 1ps

module sed_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               acc,
   input  logic [7:0]         src_byte,
   input  logic               bytes_literal,
   input  logic               body_end,
   output logic               enq,
   output sed_pkg::entry_type entry
);
   import sed_pkg::*;

   mode_type    mode_ff, mode_in, take_mode;
   logic [31:0] value_ff, value_in, take_value;
   logic [3:0]  digits_ff, digits_in, take_digits, digits_inc;
   logic        long_ff, long_in, take_long;
   logic        drain_ff, drain_in;
   logic        take_err;
   err_type     take_code;

   logic        oct_digit;
   logic        hex_ok;
   logic [3:0]  hex_val;
   logic        oct_done, hex_done, uni_done;
   logic [15:0] oct_value;
   logic [7:0]  hex_byte;
   logic [31:0] uni_value;
   logic        cp_bad;
   utf8_type    u_hex, u_uni;
   logic        end_err;
   err_type     end_code;
   entry_type   e;

   assign oct_digit  = (src_byte >= CH_0) && (src_byte <= CH_7);
   assign digits_inc = digits_ff + 4'd1;
   assign oct_done   = digits_inc >= 4'd3;
   assign hex_done   = digits_inc >= 4'd2;
   assign uni_done   = digits_inc >= (long_ff ? 4'd8 : 4'd4);
   assign oct_value  = {value_ff[12:0], src_byte[2:0]};
   assign hex_byte   = {value_ff[3:0], hex_val};
   assign uni_value  = {value_ff[27:0], hex_val};
   assign cp_bad     = (uni_value > CP_MAX) ||
                       ((uni_value >= SURR_LO) && (uni_value <= SURR_HI));
   assign u_hex      = cp_to_utf8({13'd0, hex_byte});
   assign u_uni      = cp_to_utf8(uni_value[20:0]);

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      unique case (src_byte) inside
         [CH_0:CH_9]:         hex_val = src_byte[3:0];
         [CH_LOW_A:CH_LOW_F],
         [CH_UP_A:CH_UP_F]:   hex_val = src_byte[3:0] + 4'd9;
         default:             hex_ok  = 1'b0;
      endcase
   end

   // next state of the escape machine for one byte
   always_comb begin
      take_mode   = mode_ff;
      take_value  = value_ff;
      take_digits = digits_ff;
      take_long   = long_ff;
      take_err    = 1'b0;
      take_code   = ERR_EOF;
      unique case (mode_ff)
         MODE_NORMAL: begin
            if (src_byte == CH_BSLASH) take_mode = MODE_ESC;
         end
         MODE_OCTAL: begin
            if (oct_digit) begin
               take_value  = {16'd0, oct_value};
               take_digits = digits_inc;
               if (oct_done) take_mode = MODE_NORMAL;
            end else begin
               take_mode = (src_byte == CH_BSLASH) ? MODE_ESC : MODE_NORMAL;
            end
         end
         MODE_ESC: begin
            take_mode = MODE_NORMAL;
            unique case (src_byte) inside
               CH_LOW_X: begin
                  take_mode   = MODE_HEX;
                  take_value  = '0;
                  take_digits = '0;
               end
               CH_LOW_U, CH_UP_U: begin
                  if (!bytes_literal) begin
                     take_mode   = MODE_UNI;
                     take_value  = '0;
                     take_digits = '0;
                     take_long   = (src_byte == CH_UP_U);
                  end
               end
               CH_UP_N: begin
                  if (!bytes_literal) begin
                     take_err  = 1'b1;
                     take_code = ERR_NAMED;
                  end
               end
               [CH_0:CH_7]: begin
                  take_mode   = MODE_OCTAL;
                  take_value  = {29'd0, src_byte[2:0]};
                  take_digits = 4'd1;
               end
               default: ;
            endcase
         end
         MODE_HEX: begin
            if (!hex_ok) begin
               take_err  = 1'b1;
               take_code = ERR_TRUNC_X;
            end else begin
               take_value  = {24'd0, hex_byte};
               take_digits = digits_inc;
               if (hex_done) take_mode = MODE_NORMAL;
            end
         end
         MODE_UNI: begin
            if (!hex_ok) begin
               take_err  = 1'b1;
               take_code = long_ff ? ERR_TRUNC_LONG_U : ERR_TRUNC_U;
            end else begin
               take_value  = uni_value;
               take_digits = digits_inc;
               if (uni_done) begin
                  take_mode = MODE_NORMAL;
                  if (cp_bad) begin
                     take_err  = 1'b1;
                     take_code = ERR_BAD_CP;
                  end
               end
            end
         end
         default: take_mode = MODE_NORMAL;
      endcase
   end

   always_comb begin
      mode_in   = mode_ff;
      value_in  = value_ff;
      digits_in = digits_ff;
      long_in   = long_ff;
      drain_in  = drain_ff;
      if (acc) begin
         if (body_end) begin
            mode_in   = MODE_NORMAL;
            value_in  = '0;
            digits_in = '0;
            long_in   = 1'b0;
            drain_in  = 1'b0;
         end else if (!drain_ff) begin
            mode_in   = take_mode;
            value_in  = take_value;
            digits_in = take_digits;
            long_in   = take_long;
            drain_in  = take_err;
         end
      end
   end

   // results caused by this byte
   always_comb begin
      e        = '0;
      end_err  = 1'b0;
      end_code = ERR_EOF;
      unique case (mode_ff)
         MODE_NORMAL: begin
            if (src_byte != CH_BSLASH) e = put_rec(e, KIND_BYTE, src_byte, ERR_EOF);
         end
         MODE_OCTAL: begin
            if (oct_digit) begin
               if (oct_done) e = put_rec(e, KIND_BYTE, oct_value[7:0], ERR_EOF);
            end else begin
               e = put_rec(e, KIND_BYTE, value_ff[7:0], ERR_EOF);
               if (src_byte != CH_BSLASH) e = put_rec(e, KIND_BYTE, src_byte, ERR_EOF);
            end
         end
         MODE_ESC: begin
            unique case (src_byte) inside
               CH_NL: ;
               CH_BSLASH, CH_SQUOTE, CH_DQUOTE:
                  e = put_rec(e, KIND_BYTE, src_byte, ERR_EOF);
               CH_LOW_N: e = put_rec(e, KIND_BYTE, 8'h0a, ERR_EOF);
               CH_LOW_T: e = put_rec(e, KIND_BYTE, 8'h09, ERR_EOF);
               CH_LOW_R: e = put_rec(e, KIND_BYTE, 8'h0d, ERR_EOF);
               CH_LOW_A: e = put_rec(e, KIND_BYTE, 8'h07, ERR_EOF);
               CH_LOW_B: e = put_rec(e, KIND_BYTE, 8'h08, ERR_EOF);
               CH_LOW_F: e = put_rec(e, KIND_BYTE, 8'h0c, ERR_EOF);
               CH_LOW_V: e = put_rec(e, KIND_BYTE, 8'h0b, ERR_EOF);
               CH_LOW_X, [CH_0:CH_7]: ;
               CH_LOW_U, CH_UP_U, CH_UP_N: begin
                  if (bytes_literal) begin
                     e = put_rec(e, KIND_BYTE, CH_BSLASH, ERR_EOF);
                     e = put_rec(e, KIND_BYTE, src_byte, ERR_EOF);
                  end
               end
               default: begin
                  e = put_rec(e, KIND_BYTE, CH_BSLASH, ERR_EOF);
                  e = put_rec(e, KIND_BYTE, src_byte, ERR_EOF);
               end
            endcase
         end
         MODE_HEX: begin
            if (hex_ok && hex_done) begin
               if (bytes_literal) e = put_rec(e, KIND_BYTE, hex_byte, ERR_EOF);
               else e = put_utf8(e, u_hex);
            end
         end
         MODE_UNI: begin
            if (hex_ok && uni_done && !cp_bad) e = put_utf8(e, u_uni);
         end
         default: ;
      endcase

      if (body_end && !take_err) begin
         unique case (take_mode)
            MODE_ESC: begin
               end_err  = 1'b1;
               end_code = ERR_EOF;
            end
            MODE_OCTAL: e = put_rec(e, KIND_BYTE, take_value[7:0], ERR_EOF);
            MODE_HEX: begin
               end_err  = 1'b1;
               end_code = ERR_TRUNC_X;
            end
            MODE_UNI: begin
               end_err  = 1'b1;
               end_code = take_long ? ERR_TRUNC_LONG_U : ERR_TRUNC_U;
            end
            default: ;
         endcase
      end

      if (take_err) e = put_rec(e, KIND_ERROR, 8'h00, take_code);
      else if (end_err) e = put_rec(e, KIND_ERROR, 8'h00, end_code);

      if (drain_ff) e = '0;
      if (body_end && (e.count == '0)) e = put_rec(e, KIND_MARK, 8'h00, ERR_EOF);
      e.lit_end = body_end;
   end

   assign entry = e;
   assign enq   = acc && (e.count != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_NORMAL;
         value_ff  <= '0;
         digits_ff <= '0;
         long_ff   <= 1'b0;
         drain_ff  <= 1'b0;
      end else begin
         mode_ff   <= mode_in;
         value_ff  <= value_in;
         digits_ff <= digits_in;
         long_ff   <= long_in;
         drain_ff  <= drain_in;
      end
   end

endmodule

FILE: sv/sed_queue.sv
// Short word queue between the front end and the result serializer.
`timescale 1ns / 1ps

module sed_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  sed_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output sed_pkg::entry_type head,
   output logic               empty
);
   import sed_pkg::*;

   entry_type         mem_ff [QDEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;

   assign full  = (cnt_ff == QCNT_W'(QDEPTH));
   assign empty = (cnt_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) cnt_in = cnt_ff + 1'b1;
      else if (pop && !push) cnt_in = cnt_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

FILE: sv/sed_back.sv
// Back end: hands out the results of the head queue word one at a time.
`timescale 1ns / 1ps

module sed_back (
   input  logic               clock,
   input  logic               reset,
   input  sed_pkg::entry_type head,
   input  logic               q_empty,
   output logic               q_pop,
   input  logic               rsp_pop,
   output logic               rsp_empty,
   output logic [1:0]         rsp_kind,
   output logic [7:0]         rsp_data_byte,
   output logic [2:0]         rsp_error_code,
   output logic               rsp_run_last,
   output logic               rsp_literal_end
);
   import sed_pkg::*;

   logic [IDX_W-1:0] idx_ff, idx_in;
   rec_type          cur;
   logic             last_rec;
   logic             take;

   assign cur      = head.recs[idx_ff];
   assign last_rec = ({1'b0, idx_ff} + 1'b1) == head.count;
   assign take     = rsp_pop && !q_empty;
   assign q_pop    = take && last_rec;

   assign rsp_empty       = q_empty;
   assign rsp_kind        = cur.kind;
   assign rsp_data_byte   = cur.data;
   assign rsp_error_code  = cur.code;
   assign rsp_run_last    = last_rec;
   assign rsp_literal_end = last_rec && head.lit_end;

   always_comb begin
      idx_in = idx_ff;
      if (take) idx_in = last_rec ? '0 : idx_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

FILE: sv/string_escape_decoder.sv
// Top level of the string escape decoder: front end, word queue and result serializer.
// Output: with the queue empty, the first result of a byte is on the rsp_ ports in the
// cycle after it is taken.
// Throughput: one source byte per cycle while the four-word queue has room; results
// leave one per cycle while rsp_pop is high, so a byte with several results holds the output until all are taken.
// Reset: synchronous, clears the escape state and empties the queue.
`timescale 1ns / 1ps

module string_escape_decoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   output logic       req_full,
   input  logic [7:0] req_src_byte,
   input  logic       req_bytes_literal,
   input  logic       req_body_end,
   output logic       rsp_empty,
   input  logic       rsp_pop,
   output logic [1:0] rsp_kind,
   output logic [7:0] rsp_data_byte,
   output logic [2:0] rsp_error_code,
   output logic       rsp_run_last,
   output logic       rsp_literal_end
);
   import sed_pkg::*;

   logic      acc;
   logic      enq;
   entry_type entry;
   entry_type head;
   logic      q_full, q_empty, q_pop;

   assign req_full = q_full;
   assign acc      = req_push && !q_full;

   sed_front u_front (
      .clock         (clock),
      .reset         (reset),
      .acc           (acc),
      .src_byte      (req_src_byte),
      .bytes_literal (req_bytes_literal),
      .body_end      (req_body_end),
      .enq           (enq),
      .entry         (entry)
   );

   sed_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (enq),
      .push_entry (entry),
      .full       (q_full),
      .pop        (q_pop),
      .head       (head),
      .empty      (q_empty)
   );

   sed_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head            (head),
      .q_empty         (q_empty),
      .q_pop           (q_pop),
      .rsp_pop         (rsp_pop),
      .rsp_empty       (rsp_empty),
      .rsp_kind        (rsp_kind),
      .rsp_data_byte   (rsp_data_byte),
      .rsp_error_code  (rsp_error_code),
      .rsp_run_last    (rsp_run_last),
      .rsp_literal_end (rsp_literal_end)
   );

   a_mark_ends: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_MARK) |-> (rsp_literal_end && rsp_run_last))
      else $error("end marker without literal end");

   a_err_no_data: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_kind == KIND_ERROR) |-> (rsp_data_byte == 8'h00))
      else $error("error word carries data");

   a_end_gives_word: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full && req_body_end) |=> !rsp_empty)
      else $error("literal end produced no word");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("queue not empty after reset");

endmodule
